// ===== rtl/pulse_flow_meter_totalizer_macros.svh =====
// Assertion macros for the flow meter block.
`ifndef PULSE_FLOW_METER_TOTALIZER_MACROS_SVH
`define PULSE_FLOW_METER_TOTALIZER_MACROS_SVH

// Same-cycle implication.
`define PFMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pfmt_pkg.sv =====
`default_nettype none

package pfmt_pkg;

    localparam int PERIOD_W = 16;
    localparam int TCLK_W   = 27;
    localparam int LIMIT_W  = 16;
    localparam int PPL_W    = 12;
    localparam int FLOW_W   = 16;
    localparam int TOTAL_W  = 30;
    localparam int CFG_W    = 27;
    localparam int ADDR_W   = 2;
    localparam int OUT_W    = 64;

    localparam int CAPTURE_BITS_DEF     = 16;
    localparam int TICKS_PER_MINUTE_DEF = 600;
    localparam int PPL_MAX              = 4095;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = 30'd999999999;
    localparam logic [TCLK_W-1:0]  TCLK_RST     = 27'd1000000;
    localparam logic [LIMIT_W-1:0] HIGH_RST     = 16'd8000;
    localparam logic [LIMIT_W-1:0] LOW_RST      = 16'd800;
    localparam logic [PPL_W-1:0]   PPL_RST      = 12'd200;

    localparam logic FUNC_CAPTURE = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    typedef enum logic [ADDR_W-1:0] {
        REG_TIMER_CLK = 2'd0,
        REG_HIGH_LIM  = 2'd1,
        REG_LOW_LIM   = 2'd2,
        REG_PPL       = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/pfmt_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pfmt_div
    import pfmt_pkg::*;
#(
    parameter int DVD_W = 27,
    parameter int DVS_W = 22
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_ctl_t         ctl,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_sts_t              sts,
    output logic      [DVD_W-1:0] quotient,
    output logic      [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dq_reg, dq_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, dq_reg[DVD_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        if (ctl.start)
        begin
            cnt_next = CNT_W'(DVD_W);
            rem_next = '0;
            dq_next  = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            rem_next  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dq_next   = {dq_reg[DVD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign sts.busy  = (cnt_reg != '0);
    assign sts.done  = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/pulse_flow_meter_totalizer.sv =====
// Pulse-period flow meter with a saturating litre totalizer. A beat with
// tuser = 0 carries a captured period: frequency = timer_clock_hz / period,
// clamped to high_limit_hz + 1 above the high limit (flow then equals the
// high limit, sensor_fault set) and flow forced to zero below the low limit;
// a zero period leaves all state unchanged. A beat with tuser = 1 is the
// 100 ms tick: flow is added to a fractional accumulator and whole litres,
// in units of TICKS_PER_MINUTE * pulses_per_lpm, move into the total, which
// stops at 999999999. Every input beat returns exactly one result beat that
// shows the state after it. A nonzero-period capture and a tick run through
// one shared restoring divider, one bit per cycle over the dividend width
// (27 bits at default parameters): an accepted beat passes S_START, which
// starts the divider, then S_DIV until the divider is done, then S_OUT,
// which loads the output register; the input is ready again in S_IDLE. A
// zero-period capture goes straight to S_OUT. The input is not ready while
// a beat is in progress; a finished result waits in the output register,
// and a later beat holds in its last state until that register is free.
`default_nettype none

`include "pulse_flow_meter_totalizer_macros.svh"

module pulse_flow_meter_totalizer
    import pfmt_pkg::*;
#(
    parameter int CAPTURE_BITS     = CAPTURE_BITS_DEF,
    parameter int TICKS_PER_MINUTE = TICKS_PER_MINUTE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [15:0]       s_axis_tdata,  // period_count[15:0]
    input  wire logic [0:0]        s_axis_tuser,  // func[0]
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,  // freq_hz[15:0], flow_units[31:16],
                                                  // total_liters[61:32], zero[63:62]
    output logic [0:0]             m_axis_tuser   // sensor_fault[0]
);

    localparam int CAP_EFF = (CAPTURE_BITS < PERIOD_W) ? CAPTURE_BITS : PERIOD_W;
    localparam logic [PERIOD_W-1:0] CAP_MASK = PERIOD_W'((64'd1 << CAP_EFF) - 64'd1);
    localparam int UMAX   = TICKS_PER_MINUTE * PPL_MAX;
    localparam int UNIT_W = $clog2(UMAX + 1);
    localparam int FRAC_W = $clog2(UMAX + 65535);
    localparam int DVD_W  = (TCLK_W > FRAC_W) ? TCLK_W : FRAC_W;
    localparam int DVS_W  = (PERIOD_W > UNIT_W) ? PERIOD_W : UNIT_W;
    localparam int SUM_W  = ((DVD_W > TOTAL_W) ? DVD_W : TOTAL_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic               func_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DVS_W-1:0]   dvs_reg;

    logic [TCLK_W-1:0]  tclk_reg;
    logic [LIMIT_W-1:0] high_reg;
    logic [LIMIT_W-1:0] low_reg;
    logic [PPL_W-1:0]   ppl_reg;

    logic [LIMIT_W-1:0] freq_reg;
    logic [FLOW_W-1:0]  flow_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;
    logic               m_fault_reg;

    div_ctl_t           div_ctl;
    div_sts_t           div_sts;
    logic [DVD_W-1:0]   quotient;
    logic [DVS_W-1:0]   remainder;

    logic [PERIOD_W-1:0] period;
    logic [PPL_W-1:0]    ppl_eff;
    logic [UNIT_W-1:0]   unit_val;
    logic [FRAC_W-1:0]   frac_sum;
    logic                over_high;
    logic [LIMIT_W-1:0]  clamp_freq;
    logic [LIMIT_W-1:0]  freq_new;
    logic [FLOW_W-1:0]   flow_pre;
    logic [FLOW_W-1:0]   flow_new;
    logic [SUM_W-1:0]    total_sum;
    logic [TOTAL_W-1:0]  total_new;
    logic                s_fire;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign div_ctl.start = (state_reg == S_START);

    pfmt_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (dvd_reg),
        .divisor   (dvs_reg),
        .sts       (div_sts),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        period     = s_axis_tdata & CAP_MASK;
        ppl_eff    = (ppl_reg == '0) ? PPL_W'(1) : ppl_reg;
        unit_val   = UNIT_W'(TICKS_PER_MINUTE) * UNIT_W'(ppl_eff);
        frac_sum   = frac_reg + FRAC_W'(flow_reg);
        over_high  = (quotient > DVD_W'(high_reg));
        clamp_freq = (high_reg == '1) ? high_reg : high_reg + 1'b1;
        freq_new   = over_high ? clamp_freq : quotient[LIMIT_W-1:0];
        flow_pre   = over_high ? high_reg : quotient[FLOW_W-1:0];
        flow_new   = (freq_new < low_reg) ? '0 : flow_pre;
        total_sum  = SUM_W'(total_reg) + SUM_W'(quotient);
        total_new  = (total_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tclk_reg <= TCLK_RST;
            high_reg <= HIGH_RST;
            low_reg  <= LOW_RST;
            ppl_reg  <= PPL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_TIMER_CLK: tclk_reg <= cfg_wdata[TCLK_W-1:0];
                REG_HIGH_LIM:  high_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_LOW_LIM:   low_reg  <= cfg_wdata[LIMIT_W-1:0];
                REG_PPL:       ppl_reg  <= cfg_wdata[PPL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            func_reg    <= FUNC_CAPTURE;
            dvd_reg     <= '0;
            dvs_reg     <= '0;
            freq_reg    <= '0;
            flow_reg    <= '0;
            frac_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_fault_reg <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && state_reg != S_OUT)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        func_reg <= s_axis_tuser[0];
                        if (s_axis_tuser[0] == FUNC_TICK)
                        begin
                            dvd_reg   <= DVD_W'(frac_sum);
                            dvs_reg   <= DVS_W'(unit_val);
                            state_reg <= S_START;
                        end
                        else if (period == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            dvd_reg   <= DVD_W'(tclk_reg);
                            dvs_reg   <= DVS_W'(period);
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_sts.done)
                    begin
                        if (func_reg == FUNC_TICK)
                        begin
                            frac_reg  <= remainder[FRAC_W-1:0];
                            total_reg <= total_new;
                        end
                        else
                        begin
                            freq_reg <= freq_new;
                            flow_reg <= flow_new;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {2'b00, total_reg, flow_reg, freq_reg};
                        m_fault_reg <= (freq_reg > high_reg);
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_fault_reg;

    `PFMT_ASSERT_NOW(a_total_sat, 1'b1, total_reg <= TOTAL_MAX, "total above saturation limit")
    `PFMT_ASSERT_NOW(a_ready_div_idle, s_axis_tready, !div_sts.busy && !div_sts.done,
        "input ready while divider active")
    `PFMT_ASSERT_NEXT(a_accept_busy, s_fire, !s_axis_tready, "ready right after accepted beat")
    `PFMT_ASSERT_NOW(a_done_in_div, div_sts.done, state_reg == S_DIV,
        "divider done outside divide state")

endmodule

`default_nettype wire
